/* rtl/sia_pkg.sv */
// shared types and constants for the slab item allocator
// no dependencies; used by the interfaces, slab_item_allocator_core and sia_ctrl
`timescale 1ns / 1ps
package sia_pkg;

  localparam int MAX_SLABS_DEF = 16;
  localparam int MAX_ITEMS_DEF = 64;

  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int LIMIT_W    = 5;

  localparam logic [CFG_IDX_W-1:0]  REG_ITEMS_PER_SLAB = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_SLAB_LIMIT     = 1'b1;
  localparam logic [CFG_DATA_W-1:0] ITEMS_RST          = 7'd64;
  localparam logic [LIMIT_W-1:0]    LIMIT_RST          = 5'd16;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LST_EMPTY,
    LST_PARTIAL,
    LST_FULL
  } list_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD,
    S_SWEEP,
    S_POPRD,
    S_POPLD,
    S_FCHK,
    S_ECHK,
    S_MVB,
    S_MVBW,
    S_MVA,
    S_MVAW,
    S_MVH,
    S_MVHW,
    S_MVE,
    S_WB,
    S_DONE
  } ctrl_state_t;

endpackage

/* rtl/sia_if.sv */
// request, result and configuration channels of the slab item allocator
// depends on sia_pkg
`timescale 1ns / 1ps
interface sia_req_if #(parameter int SIDX_W = 4, parameter int IIDX_W = 6);
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIDX_W-1:0] slab_index;
  logic [IIDX_W-1:0] item_index;
  modport source(output valid, func, slab_index, item_index, input ready);
  modport sink(input valid, func, slab_index, item_index, output ready);
endinterface

interface sia_res_if #(parameter int SIDX_W = 4, parameter int IIDX_W = 6);
  logic                         valid;
  logic                         ready;
  logic [sia_pkg::STATUS_W-1:0] status;
  logic [SIDX_W-1:0]            granted_slab;
  logic [IIDX_W-1:0]            granted_item;
  modport source(output valid, status, granted_slab, granted_item, input ready);
  modport sink(input valid, status, granted_slab, granted_item, output ready);
endinterface

interface sia_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sia_pkg::CFG_IDX_W-1:0]  index;
  logic [sia_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/slab_item_allocator_core.sv */
// slab item allocator top level: configuration registers and request sequencer
// depends on sia_pkg, sia_if and sia_ctrl
// a partial-slab alloc or a plain free goes straight through; each list move adds states and
// a request makes at most two; a commit first writes the initial link chain of its slab
// one request in work at a time; the next is accepted once the sequencer is idle again, as its result is presented
// reset: synchronous active-low rst_n empties all lists and clears the commit count
`timescale 1ns / 1ps
module slab_item_allocator_core #(
  parameter int MAX_SLABS          = sia_pkg::MAX_SLABS_DEF,
  parameter int MAX_ITEMS_PER_SLAB = sia_pkg::MAX_ITEMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sia_cfg_if.sink   cfg_ch,
  sia_req_if.sink   in_ch,
  sia_res_if.source out_ch
);
  import sia_pkg::*;

  localparam int SLNK_W = $clog2(MAX_SLABS + 1);
  localparam int ILNK_W = $clog2(MAX_ITEMS_PER_SLAB + 1);

  logic [CFG_DATA_W-1:0] items_cfg_r;
  logic [LIMIT_W-1:0]    limit_cfg_r;
  logic [ILNK_W-1:0]     eff_items;
  logic [SLNK_W-1:0]     eff_limit;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      items_cfg_r <= ITEMS_RST;
      limit_cfg_r <= LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ITEMS_PER_SLAB: items_cfg_r <= cfg_ch.data;
        REG_SLAB_LIMIT:     limit_cfg_r <= cfg_ch.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, large values clamp to the pool size
  always_comb begin
    if (items_cfg_r == '0) begin
      eff_items = ILNK_W'(1);
    end else if (int'(items_cfg_r) > MAX_ITEMS_PER_SLAB) begin
      eff_items = ILNK_W'(MAX_ITEMS_PER_SLAB);
    end else begin
      eff_items = ILNK_W'(items_cfg_r);
    end
    if (limit_cfg_r == '0) begin
      eff_limit = SLNK_W'(1);
    end else if (int'(limit_cfg_r) > MAX_SLABS) begin
      eff_limit = SLNK_W'(MAX_SLABS);
    end else begin
      eff_limit = SLNK_W'(limit_cfg_r);
    end
  end

  sia_ctrl #(
    .MAX_SLABS(MAX_SLABS),
    .MAX_ITEMS(MAX_ITEMS_PER_SLAB),
    .SLNK_W(SLNK_W),
    .ILNK_W(ILNK_W)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .eff_items(eff_items),
    .eff_limit(eff_limit),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );
endmodule

/* rtl/sia_ram.sv */
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module sia_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata
);
  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* rtl/sia_ctrl.sv */
// request sequencer: slab metadata ram, item link ram and the list walk
// depends on sia_pkg, sia_if and sia_ram
`timescale 1ns / 1ps
module sia_ctrl #(
  parameter int MAX_SLABS = sia_pkg::MAX_SLABS_DEF,
  parameter int MAX_ITEMS = sia_pkg::MAX_ITEMS_DEF,
  parameter int SLNK_W    = $clog2(MAX_SLABS + 1),
  parameter int ILNK_W    = $clog2(MAX_ITEMS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ILNK_W-1:0] eff_items,
  input  logic [SLNK_W-1:0] eff_limit,
  sia_req_if.sink           in_ch,
  sia_res_if.source         out_ch
);
  import sia_pkg::*;

  localparam int SIDX_W  = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int IIDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int LADDR_W = SIDX_W + IIDX_W;
  localparam int META_W  = 2 * ILNK_W + 2 * SLNK_W;
  localparam logic [SLNK_W-1:0] NO_SLAB  = SLNK_W'(MAX_SLABS);
  localparam logic [ILNK_W-1:0] NO_ITEM  = ILNK_W'(MAX_ITEMS);
  // meta word: {free count, chain head, after, before}
  localparam int BEF_LO = 0;
  localparam int AFT_LO = SLNK_W;
  localparam int HD_LO  = 2 * SLNK_W;
  localparam int CNT_LO = 2 * SLNK_W + ILNK_W;

  ctrl_state_t state_r, state_nxt, ret_r, ret_nxt;
  list_t       mv_from_r, mv_from_nxt, mv_to_r, mv_to_nxt;
  status_t     res_r, res_nxt;
  logic              func_r, func_nxt;
  logic [SIDX_W-1:0] slab_r, slab_nxt;
  logic [IIDX_W-1:0] item_r, item_nxt;
  logic [ILNK_W-1:0] cnt_r, cnt_nxt, head_r, head_nxt, sweep_r, sweep_nxt;
  logic [SLNK_W-1:0] aft_r, aft_nxt, bef_r, bef_nxt;
  logic [SLNK_W-1:0] ehead_r, ehead_nxt, phead_r, phead_nxt, fhead_r, fhead_nxt;
  logic [SLNK_W-1:0] committed_r, committed_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SIDX_W-1:0] out_slab_r, out_slab_nxt;
  logic [IIDX_W-1:0] out_item_r, out_item_nxt;

  logic [SIDX_W-1:0]  m_raddr, m_waddr;
  logic [META_W-1:0]  m_rdata, m_wdata;
  logic               m_we;
  logic [LADDR_W-1:0] l_raddr, l_waddr;
  logic [ILNK_W-1:0]  l_rdata, l_wdata;
  logic               l_we;

  sia_ram #(.DATA_W(META_W), .ADDR_W(SIDX_W)) u_meta_ram (
    .clk(clk), .raddr(m_raddr), .rdata(m_rdata),
    .we(m_we), .waddr(m_waddr), .wdata(m_wdata)
  );

  sia_ram #(.DATA_W(ILNK_W), .ADDR_W(LADDR_W)) u_link_ram (
    .clk(clk), .raddr(l_raddr), .rdata(l_rdata),
    .we(l_we), .waddr(l_waddr), .wdata(l_wdata)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.granted_slab = out_slab_r;
  assign out_ch.granted_item = out_item_r;

  always_comb begin
    logic [SLNK_W-1:0] to_head;
    logic [ILNK_W-1:0] sweep_inc;
    logic [ILNK_W-1:0] cnt_dec;
    logic [IIDX_W-1:0] pop_item;

    state_nxt     = state_r;
    ret_nxt       = ret_r;
    mv_from_nxt   = mv_from_r;
    mv_to_nxt     = mv_to_r;
    res_nxt       = res_r;
    func_nxt      = func_r;
    slab_nxt      = slab_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    sweep_nxt     = sweep_r;
    aft_nxt       = aft_r;
    bef_nxt       = bef_r;
    ehead_nxt     = ehead_r;
    phead_nxt     = phead_r;
    fhead_nxt     = fhead_r;
    committed_nxt = committed_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_status_nxt = out_status_r;
    out_slab_nxt  = out_slab_r;
    out_item_nxt  = out_item_r;

    m_raddr = slab_r;
    m_we    = 1'b0;
    m_waddr = slab_r;
    m_wdata = m_rdata;
    l_raddr = {slab_r, item_r};
    l_we    = 1'b0;
    l_waddr = {slab_r, item_r};
    l_wdata = head_r;

    case (mv_to_r)
      LST_EMPTY:   to_head = ehead_r;
      LST_PARTIAL: to_head = phead_r;
      default:     to_head = fhead_r;
    endcase
    sweep_inc = sweep_r + ILNK_W'(1);
    cnt_dec   = (cnt_r != '0) ? cnt_r - ILNK_W'(1) : cnt_r;
    pop_item  = (head_r >= NO_ITEM) ? '0 : IIDX_W'(head_r);

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt = in_ch.func;
          res_nxt  = ST_OK;
          if (in_ch.func == FUNC_FREE) begin
            slab_nxt  = in_ch.slab_index;
            item_nxt  = in_ch.item_index;
            m_raddr   = in_ch.slab_index;
            state_nxt = S_LD;
          end else if (phead_r != NO_SLAB) begin
            slab_nxt  = SIDX_W'(phead_r);
            m_raddr   = SIDX_W'(phead_r);
            state_nxt = S_LD;
          end else if (ehead_r != NO_SLAB) begin
            slab_nxt  = SIDX_W'(ehead_r);
            m_raddr   = SIDX_W'(ehead_r);
            state_nxt = S_LD;
          end else if (committed_r < eff_limit) begin
            // fresh slab: goes alone onto the partial list
            slab_nxt      = SIDX_W'(committed_r);
            committed_nxt = committed_r + SLNK_W'(1);
            cnt_nxt       = eff_items;
            head_nxt      = '0;
            aft_nxt       = NO_SLAB;
            bef_nxt       = NO_SLAB;
            phead_nxt     = committed_r;
            sweep_nxt     = '0;
            state_nxt     = S_SWEEP;
          end else begin
            res_nxt   = ST_OOM;
            state_nxt = S_DONE;
          end
        end
      end
      S_LD: begin
        cnt_nxt  = m_rdata[CNT_LO +: ILNK_W];
        head_nxt = m_rdata[HD_LO +: ILNK_W];
        aft_nxt  = m_rdata[AFT_LO +: SLNK_W];
        bef_nxt  = m_rdata[BEF_LO +: SLNK_W];
        if (func_r == FUNC_FREE) begin
          state_nxt = S_FCHK;
        end else if (phead_r == NO_SLAB) begin
          mv_from_nxt = LST_EMPTY;
          mv_to_nxt   = LST_PARTIAL;
          ret_nxt     = S_POPRD;
          state_nxt   = S_MVB;
        end else begin
          state_nxt = S_POPRD;
        end
      end
      S_SWEEP: begin
        // initial chain 0, 1, ... n-1, one link a cycle
        l_we      = 1'b1;
        l_waddr   = {slab_r, IIDX_W'(sweep_r)};
        l_wdata   = (sweep_inc < cnt_r) ? sweep_inc : NO_ITEM;
        sweep_nxt = sweep_inc;
        if (sweep_inc >= cnt_r) begin
          state_nxt = S_POPRD;
        end
      end
      S_POPRD: begin
        item_nxt  = pop_item;
        l_raddr   = {slab_r, pop_item};
        state_nxt = S_POPLD;
      end
      S_POPLD: begin
        head_nxt = l_rdata;
        cnt_nxt  = cnt_dec;
        if (cnt_dec == '0) begin
          mv_from_nxt = LST_PARTIAL;
          mv_to_nxt   = LST_FULL;
          ret_nxt     = S_WB;
          state_nxt   = S_MVB;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_FCHK: begin
        if (SLNK_W'(slab_r) >= committed_r || ILNK_W'(item_r) >= eff_items ||
            cnt_r >= eff_items) begin
          res_nxt   = ST_BAD;
          state_nxt = S_DONE;
        end else begin
          l_we     = 1'b1;
          head_nxt = ILNK_W'(item_r);
          cnt_nxt  = cnt_r + ILNK_W'(1);
          if (cnt_r == '0) begin
            mv_from_nxt = LST_FULL;
            mv_to_nxt   = LST_PARTIAL;
            ret_nxt     = S_ECHK;
            state_nxt   = S_MVB;
          end else begin
            state_nxt = S_ECHK;
          end
        end
      end
      S_ECHK: begin
        if (cnt_r == eff_items) begin
          mv_from_nxt = LST_PARTIAL;
          mv_to_nxt   = LST_EMPTY;
          ret_nxt     = S_WB;
          state_nxt   = S_MVB;
        end else begin
          state_nxt = S_WB;
        end
      end
      // unlink: predecessor's after link, or the list head
      S_MVB: begin
        if (bef_r != NO_SLAB) begin
          m_raddr   = SIDX_W'(bef_r);
          state_nxt = S_MVBW;
        end else begin
          case (mv_from_r)
            LST_EMPTY:   ehead_nxt = aft_r;
            LST_PARTIAL: phead_nxt = aft_r;
            default:     fhead_nxt = aft_r;
          endcase
          state_nxt = S_MVA;
        end
      end
      S_MVBW: begin
        m_we    = 1'b1;
        m_waddr = SIDX_W'(bef_r);
        m_wdata = m_rdata;
        m_wdata[AFT_LO +: SLNK_W] = aft_r;
        state_nxt = S_MVA;
      end
      S_MVA: begin
        if (aft_r != NO_SLAB) begin
          m_raddr   = SIDX_W'(aft_r);
          state_nxt = S_MVAW;
        end else begin
          state_nxt = S_MVH;
        end
      end
      S_MVAW: begin
        m_we    = 1'b1;
        m_waddr = SIDX_W'(aft_r);
        m_wdata = m_rdata;
        m_wdata[BEF_LO +: SLNK_W] = bef_r;
        state_nxt = S_MVH;
      end
      // push to front of the target list
      S_MVH: begin
        if (to_head != NO_SLAB) begin
          m_raddr   = SIDX_W'(to_head);
          state_nxt = S_MVHW;
        end else begin
          state_nxt = S_MVE;
        end
      end
      S_MVHW: begin
        m_we    = 1'b1;
        m_waddr = SIDX_W'(to_head);
        m_wdata = m_rdata;
        m_wdata[BEF_LO +: SLNK_W] = SLNK_W'(slab_r);
        state_nxt = S_MVE;
      end
      S_MVE: begin
        bef_nxt = NO_SLAB;
        aft_nxt = to_head;
        case (mv_to_r)
          LST_EMPTY:   ehead_nxt = SLNK_W'(slab_r);
          LST_PARTIAL: phead_nxt = SLNK_W'(slab_r);
          default:     fhead_nxt = SLNK_W'(slab_r);
        endcase
        state_nxt = ret_r;
      end
      S_WB: begin
        m_we      = 1'b1;
        m_waddr   = slab_r;
        m_wdata   = {cnt_r, head_r, aft_r, bef_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          if (res_r == ST_OK && func_r == FUNC_ALLOC) begin
            out_slab_nxt = slab_r;
            out_item_nxt = item_r;
          end else begin
            out_slab_nxt = '0;
            out_item_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      committed_r <= '0;
      ehead_r     <= NO_SLAB;
      phead_r     <= NO_SLAB;
      fhead_r     <= NO_SLAB;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      committed_r <= committed_nxt;
      ehead_r     <= ehead_nxt;
      phead_r     <= phead_nxt;
      fhead_r     <= fhead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r        <= ret_nxt;
    mv_from_r    <= mv_from_nxt;
    mv_to_r      <= mv_to_nxt;
    res_r        <= res_nxt;
    func_r       <= func_nxt;
    slab_r       <= slab_nxt;
    item_r       <= item_nxt;
    cnt_r        <= cnt_nxt;
    head_r       <= head_nxt;
    sweep_r      <= sweep_nxt;
    aft_r        <= aft_nxt;
    bef_r        <= bef_nxt;
    out_status_r <= out_status_nxt;
    out_slab_r   <= out_slab_nxt;
    out_item_r   <= out_item_nxt;
  end
endmodule

/* tb/slab_item_allocator_core_tb.sv */
// self-checking testbench for slab_item_allocator_core: directed table then random requests
// depends on sia_pkg, sia_if and the rtl top level; predicts results with its own slab model
`timescale 1ns / 1ps
module slab_item_allocator_core_tb;
  import sia_pkg::*;

  localparam int NSLAB = 16;
  localparam int NITEM = 64;
  localparam int NONE  = 16;
  localparam int LIMIT_CYCLES = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sia_cfg_if cfg_bus();
  sia_req_if req_bus();
  sia_res_if res_bus();

  slab_item_allocator_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_ch(cfg_bus.sink), .in_ch(req_bus.sink),
    .out_ch(res_bus.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] gslab;
    logic [5:0] gitem;
  } grant_t;

  // allocator shadow state
  int unsigned ips_reg, lim_reg, n_committed;
  int unsigned free_cnt[NSLAB], chain_top[NSLAB], chain_next[NSLAB*NITEM];
  int unsigned nxt[NSLAB], prv[NSLAB];
  int unsigned head_empty, head_part, head_full;
  // handles we currently hold, for well-formed frees
  logic [9:0] held[$];

  grant_t grant_q[$];
  int errors = 0;
  int n_results = 0;
  int n_sent = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit long_hold = 1'b0;

  function automatic int unsigned ips_eff();
    if (ips_reg == 0) return 1;
    if (ips_reg > NITEM) return NITEM;
    return ips_reg;
  endfunction

  function automatic int unsigned lim_eff();
    if (lim_reg == 0) return 1;
    if (lim_reg > NSLAB) return NSLAB;
    return lim_reg;
  endfunction

  task automatic list_push(inout int unsigned head, input int unsigned s);
    prv[s] = NONE;
    nxt[s] = head;
    if (head < NONE) prv[head] = s;
    head = s;
  endtask

  task automatic list_unlink(inout int unsigned head, input int unsigned s);
    int unsigned b, a;
    b = prv[s];
    a = nxt[s];
    if (b < NONE) nxt[b] = a; else head = a;
    if (a < NONE) prv[a] = b;
  endtask

  function automatic void shadow_reset();
    ips_reg = 64; lim_reg = 16; n_committed = 0;
    head_empty = NONE; head_part = NONE; head_full = NONE;
    held.delete();
  endfunction

  // computes the grant for one request and updates the shadow state
  task automatic predict_grant(input logic fn, input logic [3:0] si, input logic [5:0] ii,
                               output grant_t g);
    int unsigned n, s, it;
    bit was_full;
    n = ips_eff();
    g = '0;
    if (fn == FUNC_ALLOC) begin
      s = head_part;
      if (s >= NONE) begin
        s = head_empty;
        if (s < NONE) begin
          list_unlink(head_empty, s); list_push(head_part, s);
        end
      end
      if (s >= NONE && n_committed < lim_eff()) begin
        s = n_committed;
        n_committed++;
        free_cnt[s] = n; chain_top[s] = 0;
        for (int i = 0; i < n; i++) chain_next[s*NITEM+i] = (i + 1 < n) ? i + 1 : NITEM;
        list_push(head_part, s);
      end
      if (s >= NONE) g.status = ST_OOM;
      else begin
        it = chain_top[s];
        if (it >= NITEM) it = 0;
        chain_top[s] = chain_next[s*NITEM+it];
        if (free_cnt[s] > 0) free_cnt[s]--;
        if (free_cnt[s] == 0) begin
          list_unlink(head_part, s); list_push(head_full, s);
        end
        g.gslab = 4'(s); g.gitem = 6'(it);
        held.push_back({g.gslab, g.gitem});
      end
    end else begin
      s = si; it = ii;
      if (s >= n_committed || it >= n || free_cnt[s] >= n) g.status = ST_BAD;
      else begin
        was_full = (free_cnt[s] == 0);
        chain_next[s*NITEM+it] = chain_top[s];
        chain_top[s] = it;
        free_cnt[s]++;
        if (was_full) begin
          list_unlink(head_full, s); list_push(head_part, s);
        end
        if (free_cnt[s] == n) begin
          list_unlink(head_part, s); list_push(head_empty, s);
        end
        for (int k = 0; k < held.size(); k++)
          if (held[k] == {si, ii}) begin
            held.delete(k);
            break;
          end
      end
    end
  endtask

  initial begin
    cfg_bus.valid = 1'b0; cfg_bus.index = REG_ITEMS_PER_SLAB; cfg_bus.data = '0;
    req_bus.valid = 1'b0; req_bus.func = FUNC_ALLOC;
    req_bus.slab_index = '0; req_bus.item_index = '0;
    res_bus.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout at %0t", $time);
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        res_bus.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        res_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    grant_t got, want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got = {res_bus.status, res_bus.granted_slab, res_bus.granted_item};
      n_results++;
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = grant_q.pop_front();
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.gslab !== want.gslab)
          $display("%0t: slab expected %0d actual %0d", $time, want.gslab, got.gslab);
        if (got.gitem !== want.gitem)
          $display("%0t: item expected %0d actual %0d", $time, want.gitem, got.gitem);
        if (got !== want) errors++;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] val);
    cfg_bus.valid <= 1'b1; cfg_bus.index <= idx; cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_ITEMS_PER_SLAB) ips_reg = val; else lim_reg = val & 5'h1f;
    @(posedge clk);
  endtask

  task automatic drain();
    while (grant_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // sends one request; a typed-in expectation is checked against the prediction when given
  task automatic send_req(input logic fn, input logic [3:0] si, input logic [5:0] ii,
                          input bit typed = 1'b0, input grant_t typed_g = '0);
    grant_t g;
    if (!calm && $urandom_range(0, 7) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_bus.valid <= 1'b1; req_bus.func <= fn;
    req_bus.slab_index <= si; req_bus.item_index <= ii;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predict_grant(fn, si, ii, g);
    if (typed && g !== typed_g) begin
      $display("%0t: table row disagrees, expected %h predicted %h", $time, typed_g, g);
      errors++;
    end
    grant_q.push_back(g);
    n_sent++;
    req_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  typedef struct {
    logic fn;
    logic [3:0] si;
    logic [5:0] ii;
    bit typed;
    grant_t g;
  } row_t;

  row_t rows[] = '{
    '{FUNC_FREE,  4'd0,  6'd0,  1, '{ST_BAD, 4'd0, 6'd0}},
    '{FUNC_FREE,  4'd15, 6'd63, 1, '{ST_BAD, 4'd0, 6'd0}},
    '{FUNC_ALLOC, 4'd15, 6'd63, 1, '{ST_OK,  4'd0, 6'd0}},
    '{FUNC_ALLOC, 4'd0,  6'd0,  1, '{ST_OK,  4'd0, 6'd1}},
    '{FUNC_FREE,  4'd0,  6'd0,  1, '{ST_OK,  4'd0, 6'd0}},
    '{FUNC_ALLOC, 4'd0,  6'd0,  1, '{ST_OK,  4'd0, 6'd0}},
    '{FUNC_FREE,  4'd1,  6'd0,  1, '{ST_BAD, 4'd0, 6'd0}},
    '{FUNC_FREE,  4'd0,  6'd1,  0, '{ST_OK,  4'd0, 6'd0}},
    '{FUNC_FREE,  4'd0,  6'd0,  0, '{ST_OK,  4'd0, 6'd0}},
    '{FUNC_FREE,  4'd0,  6'd5,  1, '{ST_BAD, 4'd0, 6'd0}},
    '{FUNC_ALLOC, 4'd0,  6'd0,  0, '{ST_OK,  4'd0, 6'd0}}
  };

  task automatic random_phase(input int count, input int free_pct);
    logic [9:0] h;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < free_pct) begin
        if (held.size() != 0 && $urandom_range(0, 9) != 0) begin
          h = held[$urandom_range(0, held.size() - 1)];
          send_req(FUNC_FREE, h[9:6], h[5:0]);
        end else
          send_req(FUNC_FREE, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
      end else
        send_req(FUNC_ALLOC, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    shadow_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small slabs so out of memory and full slabs show up early
    write_reg(REG_ITEMS_PER_SLAB, 7'd2);
    write_reg(REG_SLAB_LIMIT, 7'd1);
    foreach (rows[r]) send_req(rows[r].fn, rows[r].si, rows[r].ii, rows[r].typed, rows[r].g);
    send_req(FUNC_ALLOC, 4'd0, 6'd0, 1, '{ST_OK, 4'd0, 6'd1});
    send_req(FUNC_ALLOC, 4'd0, 6'd0, 1, '{ST_OOM, 4'd0, 6'd0});
    drain();

    // register extremes, zero counts as one
    write_reg(REG_ITEMS_PER_SLAB, 7'd0);
    write_reg(REG_SLAB_LIMIT, 7'd0);
    random_phase(40, 40);
    drain();
    write_reg(REG_ITEMS_PER_SLAB, 7'd127);
    write_reg(REG_SLAB_LIMIT, 7'd31);
    long_hold = 1'b1;
    random_phase(300, 20);
    // pause the sender until everything is back
    drain();
    write_reg(REG_ITEMS_PER_SLAB, 7'd5);
    write_reg(REG_SLAB_LIMIT, 7'd4);
    random_phase(400, 50);
    drain();
    write_reg(REG_ITEMS_PER_SLAB, 7'd3);
    write_reg(REG_SLAB_LIMIT, 7'd16);
    random_phase(400, 45);
    drain();
    write_reg(REG_ITEMS_PER_SLAB, 7'd64);
    write_reg(REG_SLAB_LIMIT, 7'd2);
    calm = 1'b1;
    random_phase(400, 45);
    drain();

    $display("sent %0d requests, checked %0d results over several slab sizes and limits",
             n_sent, n_results);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
